// File: hw/rtl/topological_sort_kahn_assert.svh
// Assertion macros for the topological sort block.
`ifndef TOPOLOGICAL_SORT_KAHN_ASSERT_SVH
`define TOPOLOGICAL_SORT_KAHN_ASSERT_SVH
`ifndef SYNTHESIS
`define TSK_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TSK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TSK_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TSK_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/tsk_pkg.sv
// ---------------------------------------------------------------------------
// tsk_pkg
// Shared types for the topological sort controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none
package tsk_pkg;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load_edge;   // store the edge on the input and read its in-degree
    logic load_wb;     // write back the incremented in-degree
    logic scan_start;  // reset vertex index for the zero-degree scan
    logic scan_step;   // test one vertex
    logic deq;         // pop the queue head into current vertex
    logic edge_rd;     // issue an edge-store read
    logic deg_rd;      // read the in-degree of the edge's target
    logic edge_upd;    // update the target's in-degree
    logic emit_step;   // advance the output index
    logic clear_step;  // clear one in-degree entry
    logic clear_start; // reset index for clearing
  } tsk_cmd_t;

  typedef struct packed {
    logic scan_done;   // last vertex tested
    logic queue_empty; // head reached tail
    logic edges_done;  // last edge read issued
    logic full_order;  // tail equals vertex count
    logic emit_last;   // output index at last entry
    logic clear_done;  // last entry cleared
  } tsk_sts_t;
endpackage
`default_nettype wire

// File: hw/rtl/tsk_datapath.sv
// ---------------------------------------------------------------------------
// tsk_datapath
// Edge store, in-degree table, order queue and their counters.
// ---------------------------------------------------------------------------
`default_nettype none
module tsk_datapath import tsk_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire tsk_cmd_t cmd,
  output tsk_sts_t      sts,
  input  wire logic [6:0] n_eff,
  input  wire logic [5:0] in_src,
  input  wire logic [5:0] in_tgt,
  output logic [5:0]    out_vertex
);
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int QW = $clog2(MAX_VERTICES + 1);
  localparam int DW = CW;

  logic [11:0]   edge_mem [MAX_EDGES];
  logic [5:0]    queue_mem [MAX_VERTICES];
  logic [DW-1:0] deg_mem [MAX_VERTICES];

  logic [CW-1:0] edge_total_r;
  logic [QW-1:0] head_r, tail_r;
  logic [6:0]    idx_r;
  logic [CW-1:0] eidx_r;
  logic [5:0]    cur_r;
  logic [11:0]   edge_q_r;
  logic [5:0]    qrd_r;
  logic [DW-1:0] deg_q_r;
  logic [5:0]    ld_tgt_r;
  logic          ld_ok_r;

  wire        ld_ok = ({1'b0, in_src} < n_eff) && ({1'b0, in_tgt} < n_eff) &&
                      (edge_total_r < CW'(MAX_EDGES));
  wire [5:0]  es = edge_q_r[11:6];
  wire [5:0]  et = edge_q_r[5:0];
  wire        e_hit = (es == cur_r) && ({1'b0, es} < n_eff) && ({1'b0, et} < n_eff);
  wire [VW-1:0] iv = idx_r[VW-1:0];

  // The in-degree table has one registered read port; its address follows
  // the command of the cycle.
  wire [VW-1:0] deg_raddr = cmd.load_edge ? in_tgt[VW-1:0] :
                            (cmd.deg_rd ? et[VW-1:0] : iv);
  wire        scan_hit = cmd.scan_step && (deg_q_r == '0);
  wire        upd_dec  = cmd.edge_upd && e_hit && (deg_q_r != '0);
  wire        upd_enq  = upd_dec && (deg_q_r == DW'(1));

  always_ff @(posedge clk) begin
    if (cmd.load_edge && ld_ok)
      edge_mem[edge_total_r[EW-1:0]] <= {in_src, in_tgt};
    if (cmd.edge_rd)
      edge_q_r <= edge_mem[eidx_r[EW-1:0]];
    deg_q_r <= deg_mem[deg_raddr];
    if (cmd.load_wb && ld_ok_r)
      deg_mem[ld_tgt_r[VW-1:0]] <= deg_q_r + 1'b1;
    else if (upd_dec)
      deg_mem[et[VW-1:0]] <= deg_q_r - 1'b1;
    else if (cmd.clear_step)
      deg_mem[iv] <= '0;
    if (scan_hit)
      queue_mem[tail_r[VW-1:0]] <= 6'(iv);
    else if (upd_enq)
      queue_mem[tail_r[VW-1:0]] <= et;
    qrd_r <= queue_mem[iv];
    if (cmd.deq) cur_r <= queue_mem[head_r[VW-1:0]];
    if (cmd.load_edge) begin
      ld_tgt_r <= in_tgt;
      ld_ok_r  <= ld_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_total_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      idx_r  <= '0;
      eidx_r <= '0;
    end else begin
      if (cmd.load_edge && ld_ok) edge_total_r <= edge_total_r + 1'b1;
      if (cmd.scan_start || cmd.clear_start) idx_r <= '0;
      if (cmd.scan_start) begin
        head_r <= '0;
        tail_r <= '0;
      end
      if (cmd.scan_step) idx_r <= idx_r + 1'b1;
      if (scan_hit || upd_enq) tail_r <= tail_r + 1'b1;
      if (cmd.deq) begin
        head_r <= head_r + 1'b1;
        eidx_r <= '0;
      end
      if (cmd.edge_rd) eidx_r <= eidx_r + 1'b1;
      if (cmd.emit_step) idx_r <= idx_r + 1'b1;
      if (cmd.clear_step) begin
        idx_r <= idx_r + 1'b1;
        edge_total_r <= '0;
      end
    end
  end

  assign sts.scan_done   = (idx_r + 7'd1 >= n_eff);
  assign sts.queue_empty = (head_r >= tail_r);
  assign sts.edges_done  = (eidx_r >= edge_total_r);
  assign sts.full_order  = (7'(tail_r) >= n_eff);
  assign sts.emit_last   = (idx_r + 7'd1 >= 7'(tail_r));
  assign sts.clear_done  = (idx_r == 7'(MAX_VERTICES - 1));
  assign out_vertex      = qrd_r;
endmodule
`default_nettype wire

// File: hw/rtl/tsk_ctrl.sv
// ---------------------------------------------------------------------------
// tsk_ctrl
// Sequencer for loading, sorting, emitting and clearing.
// ---------------------------------------------------------------------------
`default_nettype none
module tsk_ctrl import tsk_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_fire,
  input  wire logic     in_op,
  input  wire logic     edges_empty,
  input  wire tsk_sts_t sts,
  output tsk_cmd_t      cmd,
  output logic          in_ready,
  output logic          emit_valid,
  output logic          emit_cycle,
  output logic          emit_last,
  input  wire logic     emit_take
);
  typedef enum logic [3:0] {
    S_IDLE, S_LD, S_SCAN_RD, S_SCAN, S_DEQ, S_ERD, S_DRD, S_EUPD,
    S_EMIT_RD, S_EMIT, S_CYC, S_CLR_ST, S_CLR
  } state_t;
  state_t state_r, state_nxt;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    in_ready = 1'b0;
    emit_valid = 1'b0;
    emit_cycle = 1'b0;
    emit_last  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire && in_op == OP_LOAD) begin
          cmd.load_edge = 1'b1;
          state_nxt = S_LD;
        end
        if (in_fire && in_op == OP_RUN) begin
          cmd.scan_start = 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_LD: begin
        cmd.load_wb = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SCAN_RD: state_nxt = S_SCAN;
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        state_nxt = sts.scan_done ? S_DEQ : S_SCAN_RD;
      end
      S_DEQ: begin
        if (sts.queue_empty) begin
          cmd.clear_start = 1'b1;
          state_nxt = sts.full_order ? S_EMIT_RD : S_CYC;
        end else begin
          cmd.deq = 1'b1;
          state_nxt = edges_empty ? S_DEQ : S_ERD;
        end
      end
      S_ERD: begin
        cmd.edge_rd = 1'b1;
        state_nxt = S_DRD;
      end
      S_DRD: begin
        cmd.deg_rd = 1'b1;
        state_nxt = S_EUPD;
      end
      S_EUPD: begin
        cmd.edge_upd = 1'b1;
        if (sts.edges_done) state_nxt = S_DEQ;
        else begin
          cmd.edge_rd = 1'b1;
          state_nxt = S_DRD;
        end
      end
      S_EMIT_RD: state_nxt = S_EMIT;
      S_EMIT: begin
        emit_valid = 1'b1;
        emit_last  = sts.emit_last;
        if (emit_take) begin
          cmd.emit_step = 1'b1;
          state_nxt = sts.emit_last ? S_CLR_ST : S_EMIT_RD;
        end
      end
      S_CYC: begin
        emit_valid = 1'b1;
        emit_cycle = 1'b1;
        emit_last  = 1'b1;
        if (emit_take) state_nxt = S_CLR_ST;
      end
      S_CLR_ST: begin
        cmd.clear_start = 1'b1;
        state_nxt = S_CLR;
      end
      S_CLR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR_ST;
    else state_r <= state_nxt;
  end
endmodule
`default_nettype wire

// File: hw/rtl/topological_sort_kahn.sv
// ---------------------------------------------------------------------------
// topological_sort_kahn
// Kahn topological sort over edges loaded one transaction at a time.
// ---------------------------------------------------------------------------
// Input channel: each transaction carries an opcode in in_tuser. A load
// transaction (opcode 0) stores one edge; the block takes it and then
// updates the target's in-degree, and takes no new load until that write
// is done. A run transaction (opcode 1) starts the sort. The scan reads and
// then tests the in-degree of every vertex, queueing those at zero; then
// each queued vertex is dequeued and, when any edge is stored, each stored
// edge is read, its target's in-degree read and then updated, since the
// edge store and the in-degree table each have one read port. Each result
// is then read and presented, and held until the receiver takes it; a stall
// simply holds the block and no input is accepted meanwhile. A graph with a
// cycle gives one result with the out_tuser cycle bit set and tlast high.
// After the results, a clearing pass wipes the in-degree table; no input is
// accepted during the run, emission or clearing.
// Reset clears all counters, sets vertex_count to 64 and starts the same
// clearing pass, during which in_tready stays low.
// ---------------------------------------------------------------------------
`default_nettype none
`include "topological_sort_kahn_assert.svh"
module topological_sort_kahn import tsk_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,  // [5:0] source_vertex, [11:6] target_vertex
  input  wire logic        in_tuser,  // opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata, // [5:0] vertex
  output logic             out_tuser, // cycle_found
  output logic             out_tlast
);
  logic [6:0] vcount_r;
  logic [6:0] n_eff;
  tsk_cmd_t cmd;
  tsk_sts_t sts;
  logic [5:0] vtx;
  logic emit_valid, emit_cycle, emit_last, edges_empty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vcount_r <= 7'd64;
    else if (cfg_we) vcount_r <= cfg_wdata;
  end

  // Effective vertex count clamped to 1..MAX_VERTICES.
  always_comb begin
    n_eff = vcount_r;
    if (n_eff == 7'd0) n_eff = 7'd1;
    if (n_eff > 7'(MAX_VERTICES)) n_eff = 7'(MAX_VERTICES);
  end

  // Tracks whether any edge is stored so a dequeue can skip the edge scan.
  always_ff @(posedge clk) begin
    if (!rst_n) edges_empty_r <= 1'b1;
    else if (cmd.load_edge && {1'b0, in_tdata[5:0]} < n_eff &&
             {1'b0, in_tdata[11:6]} < n_eff) edges_empty_r <= 1'b0;
    else if (cmd.clear_step) edges_empty_r <= 1'b1;
  end

  wire in_fire = in_tvalid && in_tready;

  tsk_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_op(in_tuser), .edges_empty(edges_empty_r),
    .sts, .cmd, .in_ready(in_tready), .emit_valid, .emit_cycle, .emit_last,
    .emit_take(out_tready)
  );

  tsk_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk, .rst_n, .cmd, .sts, .n_eff,
    .in_src(in_tdata[5:0]), .in_tgt(in_tdata[11:6]), .out_vertex(vtx)
  );

  assign out_tvalid = emit_valid;
  assign out_tdata  = {2'b00, emit_cycle ? 6'd0 : vtx};
  assign out_tuser  = emit_cycle;
  assign out_tlast  = emit_last;

  `TSK_ASSERT_IMPL(a_no_accept_while_out, clk, rst_n, out_tvalid, !in_tready)
  `TSK_ASSERT_IMPL(a_cycle_is_last, clk, rst_n, out_tvalid && out_tuser, out_tlast)
  `TSK_ASSERT_NEXT(a_run_blocks, clk, rst_n, in_fire && in_tuser, !in_tready)
endmodule
`default_nettype wire
